/* hw/rtl/bgra_to_nv12_converter_macros.svh */
// assertion macros for the pixel converter checker
// needs clk and arst_n in the scope that uses them
`ifndef BGRA_TO_NV12_CONVERTER_MACROS_SVH
`define BGRA_TO_NV12_CONVERTER_MACROS_SVH

// condition holds at every edge out of reset
`define BGNC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in one cycle implies another in the next
`define BGNC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hw/rtl/bgnc_pkg.sv */
// shared types, constants and color math for the pixel converter
// no dependencies
package bgnc_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int CFG_W = 13;
	localparam logic [CFG_W-1:0] SIZE_LIMIT = 13'd4096;
	localparam logic [CFG_W-1:0] WIDTH_RST = 13'd1920;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1080;

	localparam logic REG_FRAME_WIDTH = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int Y_R = 66;
	localparam int Y_G = 129;
	localparam int Y_B = 25;
	localparam int Y_ROUND = 128;
	localparam int Y_OFS = 16;
	localparam int CB_R = -38;
	localparam int CB_G = -74;
	localparam int CB_B = 112;
	localparam int CR_R = 112;
	localparam int CR_G = -94;
	localparam int CR_B = -18;
	// rounding plus offset of 128 folded ahead of the shift
	localparam int C_BIAS = 128 + 32768;
	localparam int C_MAX = 255;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       chroma_valid;
		logic [7:0] cb_value;
		logic [7:0] cr_value;
		logic       end_of_line;
		logic       end_of_frame;
	} result_t;

	// blue in the low bits
	typedef struct packed {
		logic [8:0] r;
		logic [8:0] g;
		logic [8:0] b;
	} pair_sum_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} avg_t;

	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] e;
		if (v == '0) begin
			e = 13'd1;
		end else if (v > SIZE_LIMIT) begin
			e = SIZE_LIMIT;
		end else begin
			e = v;
		end
		return e;
	endfunction

	function automatic logic [7:0] luma_of(input pixel_t p);
		logic [16:0] acc;
		acc = 17'(Y_R * int'(p.red) + Y_G * int'(p.green) + Y_B * int'(p.blue) + Y_ROUND);
		return 8'(acc[16:8]) + 8'(Y_OFS);
	endfunction

	function automatic logic [7:0] clamp_chroma(input logic signed [17:0] acc);
		logic [7:0] c;
		if (acc < 0) begin
			c = 8'd0;
		end else if (acc[17:8] > 10'(C_MAX)) begin
			c = 8'(C_MAX);
		end else begin
			c = acc[15:8];
		end
		return c;
	endfunction

	function automatic logic [7:0] cb_of(input avg_t a);
		logic signed [17:0] acc;
		acc = 18'(CB_R * int'(a.r) + CB_G * int'(a.g) + CB_B * int'(a.b) + C_BIAS);
		return clamp_chroma(acc);
	endfunction

	function automatic logic [7:0] cr_of(input avg_t a);
		logic signed [17:0] acc;
		acc = 18'(CR_R * int'(a.r) + CR_G * int'(a.g) + CR_B * int'(a.b) + C_BIAS);
		return clamp_chroma(acc);
	endfunction

endpackage

/* hw/rtl/bgnc_line_store.sv */
// line store for horizontal pair sums of the even row
// one write and one registered read per cycle, uses bgnc_pkg
module bgnc_line_store
	import bgnc_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF / 2,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pair_sum_t     wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pair_sum_t     rd_data
);

	pair_sum_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/bgra_to_nv12_converter.sv */
// top level of the bgr to 4:2:0 luma/chroma converter
// uses bgnc_pkg and bgnc_line_store
//
//   channel   dir  handshake            payload
//   in        in   in_valid / in_stall    pixel_t   (blue, green, red)
//   out       out  out_valid / out_stall  result_t  (luma, chroma, line and frame marks)
//   cfg       in   cfg_we                 cfg_index selects width or height
//
// one pixel per clock, sustained while out_stall stays low; a request passes stage 1, stage 2 and the result register
// the rate is set by the single write and read port of the line store
// reset gives 1920 x 1080 and starts at the first pixel of a frame
// a stalled result holds; free pipeline stages still take requests
module bgra_to_nv12_converter
	import bgnc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pixel_t           in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [12:0] DEPTH_L = 13'(DEPTH);

	logic [CFG_W-1:0] width_q, height_q;
	logic [11:0]      col_q, row_q;
	pixel_t           held_q;

	logic en_out, en2, en1, acc;

	logic [CFG_W-1:0] w_eff, h_eff;
	logic             eol, eof, odd_col, odd_row, in_range;
	logic [11:0]      idx;
	logic [AW-1:0]    addr;
	pair_sum_t        pair, rd_data;

	logic       v_s1, v_s2, out_valid_q;
	pixel_t     pix_s1;
	pair_sum_t  pair_s1;
	logic       chroma_s1, range_s1, eol_s1, eof_s1;
	logic [7:0] luma_s2;
	avg_t       avg_s2;
	logic       chroma_s2, eol_s2, eof_s2;
	result_t    out_q;

	pair_sum_t upper;
	avg_t      avg;
	logic [9:0] tot_b, tot_g, tot_r;

	assign en_out = !out_valid_q || !out_stall;
	assign en2 = !v_s2 || en_out;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign acc = in_valid && en1;

	assign w_eff = eff_size(width_q);
	assign h_eff = eff_size(height_q);
	assign eol = ({1'b0, col_q} + 13'd1) >= w_eff;
	assign eof = eol && (({1'b0, row_q} + 13'd1) >= h_eff);
	assign odd_col = col_q[0];
	assign odd_row = row_q[0];
	assign idx = {1'b0, col_q[11:1]};
	assign in_range = {1'b0, idx} < DEPTH_L;
	assign addr = AW'(idx);

	assign pair.b = {1'b0, in_data.blue} + {1'b0, held_q.blue};
	assign pair.g = {1'b0, in_data.green} + {1'b0, held_q.green};
	assign pair.r = {1'b0, in_data.red} + {1'b0, held_q.red};

	bgnc_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line (
		.clk     (clk),
		.wr_en   (acc && odd_col && !odd_row && in_range),
		.wr_addr (addr),
		.wr_data (pair),
		.rd_en   (acc && odd_col && odd_row && in_range),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: width_q <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			held_q <= '0;
		end else if (acc) begin
			held_q <= in_data;
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	// stage 1: pixel, pair sums and flags, line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= in_data;
			pair_s1 <= pair;
			chroma_s1 <= odd_col && odd_row;
			range_s1 <= in_range;
			eol_s1 <= eol;
			eof_s1 <= eof;
		end
	end

	// stage 2: luma and block averages
	assign upper = range_s1 ? rd_data : '0;
	assign tot_b = {1'b0, pair_s1.b} + {1'b0, upper.b};
	assign tot_g = {1'b0, pair_s1.g} + {1'b0, upper.g};
	assign tot_r = {1'b0, pair_s1.r} + {1'b0, upper.r};
	assign avg.b = tot_b[9:2];
	assign avg.g = tot_g[9:2];
	assign avg.r = tot_r[9:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			luma_s2 <= luma_of(pix_s1);
			avg_s2 <= avg;
			chroma_s2 <= chroma_s1;
			eol_s2 <= eol_s1;
			eof_s2 <= eof_s1;
		end
	end

	// result register: chroma weights and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_q.luma <= luma_s2;
			out_q.chroma_valid <= chroma_s2;
			out_q.cb_value <= chroma_s2 ? cb_of(avg_s2) : 8'd0;
			out_q.cr_value <= chroma_s2 ? cr_of(avg_s2) : 8'd0;
			out_q.end_of_line <= eol_s2;
			out_q.end_of_frame <= eof_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* hw/rtl/bgnc_checker.sv */
// port-level checks for the pixel converter, bound to the top level
// uses bgnc_pkg and bgra_to_nv12_converter_macros.svh
`include "bgra_to_nv12_converter_macros.svh"

module bgnc_checker
	import bgnc_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_stall,
	input result_t out_data
);

	`BGNC_ASSERT_ALWAYS(a_frame_ends_line, !out_valid || !out_data.end_of_frame || out_data.end_of_line, "frame end without line end")
	`BGNC_ASSERT_ALWAYS(a_chroma_zero, !out_valid || out_data.chroma_valid || (out_data.cb_value == 8'd0 && out_data.cr_value == 8'd0), "chroma set without block")
	`BGNC_ASSERT_ALWAYS(a_luma_range, !out_valid || (out_data.luma >= 8'd16 && out_data.luma <= 8'd235), "luma out of studio range")
	`BGNC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind bgra_to_nv12_converter bgnc_checker u_bgnc_checker (.*);
